/* src/phr_pkg.sv */
// shared types, constants and codes for the palette hue replacement block
package phr_pkg;

    // field widths
    localparam int ChanW   = 8;
    localparam int NumW    = 6;
    localparam int DenW    = 7;
    localparam int QuoW    = 8;
    localparam int RemW    = DenW + QuoW;
    localparam int CfgIdxW = 2;

    // quotient bits resolved per divider stage
    localparam int DivSteps      = QuoW;
    localparam int StepsPerStage = 2;
    localparam int DivStages     = DivSteps / StepsPerStage;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_NEW_HUE     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_FIRST_ENTRY = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LAST_ENTRY  = 2'd2;

    // configuration reset values
    localparam logic [ChanW-1:0] NewHueRst     = 8'd0;
    localparam logic [ChanW-1:0] FirstEntryRst = 8'd0;
    localparam logic [ChanW-1:0] LastEntryRst  = 8'd255;

    // hue byte landmarks: 120, 240 and 360 degrees
    localparam logic [ChanW-1:0] Hue120 = 8'd85;
    localparam logic [ChanW-1:0] Hue240 = 8'd170;
    localparam logic [ChanW-1:0] Hue360 = 8'd255;

    // last hue byte of each sector
    localparam logic [ChanW-1:0] SecEndRy = 8'd42;
    localparam logic [ChanW-1:0] SecEndYg = 8'd85;
    localparam logic [ChanW-1:0] SecEndGc = 8'd127;
    localparam logic [ChanW-1:0] SecEndCb = 8'd170;
    localparam logic [ChanW-1:0] SecEndBm = 8'd212;

    // hue sectors: red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta,
    // magenta-red
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        logic [ChanW-1:0] entry_index;
        logic [ChanW-1:0] red_in;
        logic [ChanW-1:0] green_in;
        logic [ChanW-1:0] blue_in;
    } entry_t;

    typedef struct packed {
        logic [ChanW-1:0] index_out;
        logic [ChanW-1:0] red_out;
        logic [ChanW-1:0] green_out;
        logic [ChanW-1:0] blue_out;
        logic             was_changed;
    } result_t;

    // item state carried down the pipeline
    typedef struct packed {
        logic [ChanW-1:0] idx;
        logic             changed;
        sector_t          sector;
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] mx;
        logic [ChanW-1:0] mn;
        logic [NumW-1:0]  num;
        logic [DenW-1:0]  den;
        logic [RemW-1:0]  rem;
        logic [QuoW-1:0]  quo;
    } work_t;

endpackage

/* src/palette_hue_replace.sv */
// top level of the palette hue replacement block
//
// Recolors palette entries: an entry whose index lies in [first_entry, last_entry]
// keeps its largest and smallest channel and takes the hue new_hue; the middle
// channel becomes min + floor((max - min) * num / den) for the hue sector.
// Other entries pass through unchanged with was_changed low.
// Input channel: an item is taken at a clock edge with start high and busy low.
// busy is low in every cycle after the first one following reset, so an item
// can enter on every clock.
// Output channel: done marks result for exactly one cycle, once the item has passed
// the input, multiply, divider and output registers; results leave in order, one per
// item. The receiver cannot stall, so nothing is held back.
// Pipeline: input stage, multiply stage, four divider stages of two quotient bits
// each, and the output register. Throughput is one item a cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// new_hue, 1 first_entry, 2 last_entry, other indexes are ignored. Write only
// while no item is in flight.
// Reset (rst_n low, asynchronous) empties the pipeline and restores new_hue 0,
// first_entry 0, last_entry 255; busy is high and cfg_ready low until the first
// clock edge after reset is released.
module palette_hue_replace (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  phr_pkg::entry_t            entry,
    output logic                       done,
    output phr_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [phr_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [phr_pkg::ChanW-1:0]  cfg_data
);
    import phr_pkg::*;

    logic             run_reg;
    logic [ChanW-1:0] new_hue_reg;
    logic [ChanW-1:0] first_entry_reg;
    logic [ChanW-1:0] last_entry_reg;
    logic             take;
    logic             cfg_write;
    logic             stage_valid [DivStages+1];
    work_t            stage_work  [DivStages+1];

    assign busy      = ~run_reg;
    assign cfg_ready = run_reg;
    assign take      = start & run_reg;
    assign cfg_write = cfg_valid & run_reg;

    // run flag and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg         <= 1'b0;
            new_hue_reg     <= NewHueRst;
            first_entry_reg <= FirstEntryRst;
            last_entry_reg  <= LastEntryRst;
        end
        else
        begin
            run_reg <= 1'b1;
            if (cfg_write)
            begin
                if (cfg_index == CFG_NEW_HUE)
                begin
                    new_hue_reg <= cfg_data;
                end
                if (cfg_index == CFG_FIRST_ENTRY)
                begin
                    first_entry_reg <= cfg_data;
                end
                if (cfg_index == CFG_LAST_ENTRY)
                begin
                    last_entry_reg <= cfg_data;
                end
            end
        end
    end

    // range check, max/min and product
    phr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .entry       (entry),
        .new_hue     (new_hue_reg),
        .first_entry (first_entry_reg),
        .last_entry  (last_entry_reg),
        .work_valid  (stage_valid[0]),
        .work        (stage_work[0])
    );

    // divider chain
    for (genvar s = 0; s < DivStages; s++)
    begin : g_div
        phr_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[s]),
            .in_work   (stage_work[s]),
            .out_valid (stage_valid[s+1]),
            .out_work  (stage_work[s+1])
        );
    end

    // channel placement and result register
    phr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[DivStages]),
        .in_work  (stage_work[DivStages]),
        .done     (done),
        .result   (result)
    );

endmodule

/* src/phr_front.sv */
// front stages: range check, max/min, sector decode, then spread times numerator
module phr_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  phr_pkg::entry_t          entry,
    input  logic [phr_pkg::ChanW-1:0] new_hue,
    input  logic [phr_pkg::ChanW-1:0] first_entry,
    input  logic [phr_pkg::ChanW-1:0] last_entry,
    output logic                     work_valid,
    output phr_pkg::work_t           work
);
    import phr_pkg::*;

    logic             s1_valid_reg;
    work_t            s1_reg;
    work_t            s1_next;
    logic             s2_valid_reg;
    work_t            s2_reg;
    work_t            s2_next;
    logic [ChanW-1:0] mx_rg;
    logic [ChanW-1:0] mn_rg;
    logic [ChanW-1:0] num_w;
    logic [ChanW-1:0] den_w;
    logic [ChanW-1:0] spread;
    sector_t          sector;

    // max and min of the red and green channels; blue joins in stage 1
    always_comb
    begin
        mx_rg = (entry.red_in > entry.green_in) ? entry.red_in : entry.green_in;
        mn_rg = (entry.red_in < entry.green_in) ? entry.red_in : entry.green_in;
    end

    // hue sector and the fraction of the spread for the middle channel
    always_comb
    begin
        priority if (new_hue <= SecEndRy)
        begin
            sector = SEC_RY;
            num_w  = new_hue;
            den_w  = Hue120 - new_hue;
        end
        else if (new_hue <= SecEndYg)
        begin
            sector = SEC_YG;
            num_w  = Hue120 - new_hue;
            den_w  = new_hue;
        end
        else if (new_hue <= SecEndGc)
        begin
            sector = SEC_GC;
            num_w  = new_hue - Hue120;
            den_w  = Hue240 - new_hue;
        end
        else if (new_hue <= SecEndCb)
        begin
            sector = SEC_CB;
            num_w  = Hue240 - new_hue;
            den_w  = new_hue - Hue120;
        end
        else if (new_hue <= SecEndBm)
        begin
            sector = SEC_BM;
            num_w  = new_hue - Hue240;
            den_w  = Hue360 - new_hue;
        end
        else
        begin
            sector = SEC_MR;
            num_w  = Hue360 - new_hue;
            den_w  = new_hue - Hue240;
        end
    end

    // stage 1 contents
    always_comb
    begin
        s1_next         = '0;
        s1_next.idx     = entry.entry_index;
        s1_next.changed = (entry.entry_index >= first_entry) &&
                          (entry.entry_index <= last_entry);
        s1_next.sector  = sector;
        s1_next.red     = entry.red_in;
        s1_next.green   = entry.green_in;
        s1_next.blue    = entry.blue_in;
        s1_next.mx      = (mx_rg > entry.blue_in) ? mx_rg : entry.blue_in;
        s1_next.mn      = (mn_rg < entry.blue_in) ? mn_rg : entry.blue_in;
        s1_next.num     = num_w[NumW-1:0];
        s1_next.den     = den_w[DenW-1:0];
    end

    // stage 2: product of spread and numerator seeds the divider
    always_comb
    begin
        spread      = s1_reg.mx - s1_reg.mn;
        s2_next     = s1_reg;
        s2_next.rem = RemW'(spread * s1_reg.num);
        s2_next.quo = '0;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign work_valid = s2_valid_reg;
    assign work       = s2_reg;

endmodule

/* src/phr_div_stage.sv */
// one divider stage: resolves two quotient bits (StepsPerStage) by restoring division
module phr_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  phr_pkg::work_t in_work,
    output logic           out_valid,
    output phr_pkg::work_t out_work
);
    import phr_pkg::*;

    logic            valid_reg;
    work_t           work_reg;
    work_t           work_next;
    logic [RemW-1:0] divisor;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;

    // compare against the divisor aligned to the top quotient bit, shift per step
    always_comb
    begin
        divisor = RemW'({in_work.den, {(QuoW-1){1'b0}}});
        rem     = in_work.rem;
        quo     = in_work.quo;
        for (int i = 0; i < StepsPerStage; i++)
        begin
            if (rem >= divisor)
            begin
                rem = rem - divisor;
                quo = {quo[QuoW-2:0], 1'b1};
            end
            else
            begin
                quo = {quo[QuoW-2:0], 1'b0};
            end
            rem = {rem[RemW-2:0], 1'b0};
        end
        work_next     = in_work;
        work_next.rem = rem;
        work_next.quo = quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

/* src/phr_back.sv */
// back stage: middle value and channel placement into the result register
module phr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  phr_pkg::work_t   in_work,
    output logic             done,
    output phr_pkg::result_t result
);
    import phr_pkg::*;

    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;
    logic [ChanW-1:0] mid;

    // place max, mid and min by sector; untouched entries pass through
    always_comb
    begin
        mid                     = in_work.mn + in_work.quo;
        result_next.index_out   = in_work.idx;
        result_next.was_changed = in_work.changed;
        result_next.red_out     = in_work.red;
        result_next.green_out   = in_work.green;
        result_next.blue_out    = in_work.blue;
        if (in_work.changed)
        begin
            unique case (in_work.sector)
                SEC_RY:
                begin
                    result_next.red_out   = in_work.mx;
                    result_next.green_out = mid;
                    result_next.blue_out  = in_work.mn;
                end
                SEC_YG:
                begin
                    result_next.red_out   = mid;
                    result_next.green_out = in_work.mx;
                    result_next.blue_out  = in_work.mn;
                end
                SEC_GC:
                begin
                    result_next.red_out   = in_work.mn;
                    result_next.green_out = in_work.mx;
                    result_next.blue_out  = mid;
                end
                SEC_CB:
                begin
                    result_next.red_out   = in_work.mn;
                    result_next.green_out = mid;
                    result_next.blue_out  = in_work.mx;
                end
                SEC_BM:
                begin
                    result_next.red_out   = mid;
                    result_next.green_out = in_work.mn;
                    result_next.blue_out  = in_work.mx;
                end
                SEC_MR:
                begin
                    result_next.red_out   = in_work.mx;
                    result_next.green_out = in_work.mn;
                    result_next.blue_out  = mid;
                end
                default:
                begin
                    result_next.red_out   = in_work.mx;
                    result_next.green_out = mid;
                    result_next.blue_out  = in_work.mn;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* src/phr_checker.sv */
// port-level checker for the palette hue replacement block, with its bind
module phr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input phr_pkg::entry_t             entry,
    input logic                        done,
    input phr_pkg::result_t            result
);
    import phr_pkg::*;

    logic take;
    assign take = start && !busy;

    // every item gives a result, marked by done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##7 done)
        else $error("item without result after seven cycles");

    // no result without a matching item
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, 7))
        else $error("result without a matching item");

    // index travels with its item
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.index_out == $past(entry.entry_index, 7))
        else $error("index out of step with its item");

    // entries outside the range pass through unchanged
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.was_changed |->
            result.red_out == $past(entry.red_in, 7) &&
            result.green_out == $past(entry.green_in, 7) &&
            result.blue_out == $past(entry.blue_in, 7))
        else $error("unchanged entry altered");

    // a recolored black entry stays black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.was_changed && $past(entry.red_in, 7) == '0 &&
            $past(entry.green_in, 7) == '0 && $past(entry.blue_in, 7) == '0 |->
            result.red_out == '0 && result.green_out == '0 && result.blue_out == '0)
        else $error("black entry recolored to nonzero");

endmodule

bind palette_hue_replace phr_checker u_phr_checker (.*);
